@@ src/b64_pkg.sv @@
`timescale 1ns / 1ps

package b64_pkg;

    // Register map
    localparam int unsigned RegDirection = 0;
    localparam int unsigned AddrWidth    = 3;

    localparam logic DirEncode = 1'b0;
    localparam logic DirDecode = 1'b1;

    localparam logic [7:0] CharPad = 8'h3D;  // '='

    // Decoded form of one base64 character
    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] val;
    } char_dec_t;

    // One result held for the output side
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       bad;
        logic       trunc;
    } res_t;

    // Map a six-bit value to its alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] six);
        logic [7:0] s;
        s = {2'b00, six};
        if (six < 6'd26)
            return s + 8'd65;            // 'A'..'Z'
        else if (six < 6'd52)
            return s + 8'd71;            // 'a'..'z'
        else if (six < 6'd62)
            return s - 8'd4;             // '0'..'9'
        else if (six == 6'd62)
            return 8'h2B;                // '+'
        else
            return 8'h2F;                // '/'
    endfunction

    // Classify a character code and take its six-bit value
    function automatic char_dec_t b64_decode(input logic [7:0] c);
        char_dec_t d;
        d.bad = 1'b0;
        d.pad = 1'b0;
        d.val = '0;
        if (c >= 8'h41 && c <= 8'h5A)
            d.val = 6'(c - 8'd65);
        else if (c >= 8'h61 && c <= 8'h7A)
            d.val = 6'(c - 8'd71);
        else if (c >= 8'h30 && c <= 8'h39)
            d.val = 6'(c + 8'd4);
        else if (c == 8'h2B)
            d.val = 6'd62;
        else if (c == 8'h2F)
            d.val = 6'd63;
        else if (c == CharPad)
            d.pad = 1'b1;
        else
            d.bad = 1'b1;
        return d;
    endfunction

endpackage

@@ src/base64_stream_codec.sv @@
`timescale 1ns / 1ps
// Latency: the first result of an item is shown on the cycle after its transfer.
// Throughput: one result per cycle while m_tready is high, from a four-entry result buffer;
// input is held off until the last result of the current run transfers.
// Reset: rst_n clears direction (encode), the group fill count and empties the buffer.

module base64_stream_codec
(
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] in_byte
    input  logic                           s_tlast,   // in_last
    // master side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [7:0] out_byte, [8] out_valid
    output logic                           m_tlast,   // run_last
    output logic [2:0]                     m_tuser,   // [0] stream_end, [1] bad_group,
                                                      // [2] truncated
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [b64_pkg::AddrWidth-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import b64_pkg::*;

    logic              dir_reg;
    logic [1:0]        fill_reg, fill_next;
    logic [7:0]        store_reg [3];
    logic [2:0]        cnt_reg;
    logic [1:0]        idx_reg;
    logic              last_reg;
    res_t              buf_reg [4];
    res_t              res [4];
    logic [2:0]        res_cnt;
    logic              cfg_wr;
    logic              in_xfer;
    logic              out_xfer;
    logic              store_en;
    logic [1:0]        store_idx;
    char_dec_t         v0, v1, v2, v3;
    logic              grp_bad;
    res_t              cur;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'(RegDirection));
    assign prdata = (paddr[2] == 1'(RegDirection)) ? {31'b0, dir_reg} : '0;

    // Handshakes
    assign m_tvalid = (cnt_reg != 3'd0);
    assign cur      = buf_reg[idx_reg];
    assign m_tlast  = ({1'b0, idx_reg} == cnt_reg - 3'd1);
    assign m_tdata  = {7'b0, cur.valid, cur.data};
    assign m_tuser  = {cur.trunc, cur.bad, m_tlast && last_reg};
    assign out_xfer = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || (m_tready && m_tlast);
    assign in_xfer  = s_tvalid && s_tready;

    // Decode the held group with the new character
    assign v0 = b64_decode(store_reg[0]);
    assign v1 = b64_decode(store_reg[1]);
    assign v2 = b64_decode(store_reg[2]);
    assign v3 = b64_decode(s_tdata);
    assign grp_bad = v0.bad || v0.pad || v1.bad || v1.pad || v2.bad || v3.bad
                     || (v2.pad && !v3.pad);

    // Work out the results of the offered item and the next group state
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            res[k] = '0;
        end
        res_cnt   = 3'd0;
        fill_next = fill_reg;
        store_en  = 1'b0;
        store_idx = fill_reg;
        if (dir_reg == DirEncode)
        begin
            if (fill_reg < 2'd2 && !s_tlast)
            begin
                store_en  = 1'b1;
                store_idx = {1'b0, fill_reg[0]};
                fill_next = fill_reg + 2'd1;
            end
            else
            begin
                fill_next = 2'd0;
                res_cnt   = 3'd4;
                for (int k = 0; k < 4; k++)
                begin
                    res[k].valid = 1'b1;
                end
                case (fill_reg)
                    2'd0:
                    begin
                        res[0].data = b64_char(s_tdata[7:2]);
                        res[1].data = b64_char({s_tdata[1:0], 4'b0});
                        res[2].data = CharPad;
                        res[3].data = CharPad;
                    end
                    2'd1:
                    begin
                        res[0].data = b64_char(store_reg[0][7:2]);
                        res[1].data = b64_char({store_reg[0][1:0], s_tdata[7:4]});
                        res[2].data = b64_char({s_tdata[3:0], 2'b0});
                        res[3].data = CharPad;
                    end
                    default:
                    begin
                        res[0].data = b64_char(store_reg[0][7:2]);
                        res[1].data = b64_char({store_reg[0][1:0], store_reg[1][7:4]});
                        res[2].data = b64_char({store_reg[1][3:0], s_tdata[7:6]});
                        res[3].data = b64_char(s_tdata[5:0]);
                    end
                endcase
            end
        end
        else
        begin
            if (fill_reg < 2'd3)
            begin
                store_en  = 1'b1;
                fill_next = fill_reg + 2'd1;
                if (s_tlast)
                begin
                    fill_next    = 2'd0;
                    res_cnt      = 3'd1;
                    res[0].trunc = 1'b1;
                end
            end
            else
            begin
                fill_next = 2'd0;
                if (grp_bad)
                begin
                    res_cnt    = 3'd1;
                    res[0].bad = 1'b1;
                end
                else
                begin
                    res[0].valid = 1'b1;
                    res[0].data  = {v0.val, v1.val[5:4]};
                    res[1].valid = 1'b1;
                    res[1].data  = {v1.val[3:0], v2.val[5:2]};
                    res[2].valid = 1'b1;
                    res[2].data  = {v2.val[1:0], v3.val};
                    if (v2.pad)
                        res_cnt = 3'd1;
                    else if (v3.pad)
                        res_cnt = 3'd2;
                    else
                        res_cnt = 3'd3;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= DirEncode;
            fill_reg <= 2'd0;
            cnt_reg  <= 3'd0;
            idx_reg  <= 2'd0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                dir_reg  <= pwdata[0];
                fill_reg <= 2'd0;
            end
            else if (in_xfer)
            begin
                fill_reg <= fill_next;
            end
            // load a new run, else advance or drop the current one
            if (in_xfer && res_cnt != 3'd0)
            begin
                cnt_reg  <= res_cnt;
                idx_reg  <= 2'd0;
                last_reg <= s_tlast;
            end
            else if (out_xfer)
            begin
                if (m_tlast)
                begin
                    cnt_reg <= 3'd0;
                    idx_reg <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    // Group store and result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && store_en)
        begin
            store_reg[store_idx] <= s_tdata;
        end
        if (in_xfer && res_cnt != 3'd0)
        begin
            for (int k = 0; k < 4; k++)
            begin
                buf_reg[k] <= res[k];
            end
        end
    end

`ifndef SYNTHESIS
    // Read index stays inside the loaded run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("result index beyond run length");

    // Encode never holds three bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (dir_reg == DirEncode) |-> (fill_reg != 2'd3))
        else $error("encode group overfilled");

    // Status-only results are always the single result of their item
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !cur.valid) |-> (m_tlast && idx_reg == 2'd0))
        else $error("status result not alone in its run");

    // A transfer that produces results is taken only when the buffer frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && res_cnt != 3'd0) |=> (m_tvalid && idx_reg == 2'd0))
        else $error("new run not presented");
`endif

endmodule
